### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle
`define DWMD_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the following cycle
`define DWMD_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

### design/dwmd_pkg.sv
// ----------------------------------------------------------------------------
// dwmd_pkg
// Shared types and fixed constants of the distinct window marker detector.
// ----------------------------------------------------------------------------
`default_nettype none

package dwmd_pkg;

   // Fixed field widths
   localparam int unsigned DATA_W       = 8;
   localparam int unsigned CFG_W        = 6;
   localparam int unsigned OUT_POS_W    = 16;
   localparam int unsigned BYTE_VALUES  = 256;

   // Window length after reset
   localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd14;

   // Table write command from the run tracker
   typedef struct packed {
      logic wr_en;    // record the byte position
      logic clr_all;  // drop every entry (string ended)
   } tbl_ctrl_type;

endpackage

`default_nettype wire

### design/dwmd_req_if.sv
// ----------------------------------------------------------------------------
// dwmd_req_if
// Byte channel: one data byte and an end-of-string flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwmd_req_if;
   logic                        valid;
   logic                        ready;
   logic [dwmd_pkg::DATA_W-1:0] data_byte;
   logic                        last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

### design/dwmd_rsp_if.sv
// ----------------------------------------------------------------------------
// dwmd_rsp_if
// Result channel: marker position and found flag per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface dwmd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dwmd_pkg::OUT_POS_W-1:0] marker_position;
   logic                           marker_found;

   modport source (output valid, output marker_position, output marker_found, input ready);
   modport sink   (input valid, input marker_position, input marker_found, output ready);
endinterface

`default_nettype wire

### design/dwmd_pos_table.sv
// ----------------------------------------------------------------------------
// dwmd_pos_table
// Last-seen position of every byte value: a synchronous memory with a
// registered read port, plus one valid flag per byte value.
// ----------------------------------------------------------------------------
`default_nettype none

module dwmd_pos_table #(
   parameter int unsigned POS_W = 17
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // read port, registered read data
   input  wire logic                        rd_en,
   input  wire logic [dwmd_pkg::DATA_W-1:0] rd_addr,
   output      logic [POS_W-1:0]            rd_data,
   // valid lookup for the byte in the compare stage
   input  wire logic [dwmd_pkg::DATA_W-1:0] chk_addr,
   output      logic                        chk_seen,
   // write port
   input  wire dwmd_pkg::tbl_ctrl_type      ctrl,
   input  wire logic [dwmd_pkg::DATA_W-1:0] wr_addr,
   input  wire logic [POS_W-1:0]            wr_data
);

   logic [POS_W-1:0]                  pos_mem [dwmd_pkg::BYTE_VALUES];
   logic [POS_W-1:0]                  rd_data_ff;
   logic [dwmd_pkg::BYTE_VALUES-1:0]  seen_ff;
   logic [dwmd_pkg::BYTE_VALUES-1:0]  seen_in;

   // Write the position memory
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         pos_mem[wr_addr] <= wr_data;
      end
   end

   // Read the position memory
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= pos_mem[rd_addr];
      end
   end

   // Set a flag on write, clear all at end of string
   always_comb begin
      seen_in = seen_ff;
      if (ctrl.clr_all) begin
         seen_in = '0;
      end else if (ctrl.wr_en) begin
         seen_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   assign rd_data  = rd_data_ff;
   assign chk_seen = seen_ff[chk_addr];

endmodule

`default_nettype wire

### design/dwmd_run_tracker.sv
// ----------------------------------------------------------------------------
// dwmd_run_tracker
// Per-string state: repeat-free run length, byte count and marker flag.
// Computes the result of one byte and the table update.
// ----------------------------------------------------------------------------
`default_nettype none

module dwmd_run_tracker #(
   parameter int unsigned WINDOW_MAX   = 32,
   parameter int unsigned POSITION_MAX = 65535,
   parameter int unsigned POS_W        = 17,
   parameter int unsigned RUN_W        = 6
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           fire,
   input  wire logic                           last_byte,
   input  wire logic                           seen,
   input  wire logic [POS_W-1:0]               last_pos,
   input  wire logic [dwmd_pkg::CFG_W-1:0]     window_length,
   output      dwmd_pkg::tbl_ctrl_type         tbl_ctrl,
   output      logic [POS_W-1:0]               wr_pos,
   output      logic                           res_vld,
   output      logic                           res_found,
   output      logic [dwmd_pkg::OUT_POS_W-1:0] res_pos
);

   localparam int unsigned SPAN_MAX = WINDOW_MAX - 1;

   logic [RUN_W-1:0] run_ff,      run_in;
   logic [POS_W-1:0] count_ff,    count_in;
   logic             reported_ff, reported_in;

   logic [POS_W-1:0] cnt_new;
   logic [POS_W-1:0] gap_len;
   logic [RUN_W-1:0] span;
   logic [RUN_W-1:0] run_inc;
   logic [RUN_W-1:0] new_run;
   logic [RUN_W-1:0] eff_win;
   logic             repeat_hit;
   logic             marker;

   always_comb begin
      // Count this byte, saturate one past the largest position
      cnt_new = (count_ff <= POS_W'(POSITION_MAX)) ? count_ff + POS_W'(1) : count_ff;

      // Nearest earlier copy inside the current run ends the run
      gap_len    = cnt_new - last_pos;
      span       = (run_ff < RUN_W'(SPAN_MAX)) ? run_ff : RUN_W'(SPAN_MAX);
      repeat_hit = seen && (gap_len <= POS_W'(span));
      run_inc    = (run_ff < RUN_W'(WINDOW_MAX)) ? run_ff + RUN_W'(1) : run_ff;
      new_run    = repeat_hit ? gap_len[RUN_W-1:0] : run_inc;

      // Clamp the configured window length
      if (window_length == '0) begin
         eff_win = RUN_W'(1);
      end else if (8'(window_length) > 8'(WINDOW_MAX)) begin
         eff_win = RUN_W'(WINDOW_MAX);
      end else begin
         eff_win = RUN_W'(window_length);
      end

      marker = !reported_ff && (new_run >= eff_win) &&
               (cnt_new <= POS_W'(POSITION_MAX));

      // Result of this byte
      res_vld   = fire && (marker || (last_byte && !reported_ff));
      res_found = marker;
      res_pos   = marker ? dwmd_pkg::OUT_POS_W'(cnt_new) : '0;

      // Table update
      tbl_ctrl.wr_en   = fire && !last_byte;
      tbl_ctrl.clr_all = fire && last_byte;
      wr_pos           = cnt_new;

      // Next state, restart after the last byte
      run_in      = run_ff;
      count_in    = count_ff;
      reported_in = reported_ff;
      if (fire) begin
         if (last_byte) begin
            run_in      = '0;
            count_in    = '0;
            reported_in = 1'b0;
         end else begin
            run_in      = new_run;
            count_in    = cnt_new;
            reported_in = reported_ff || marker;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= '0;
         count_ff    <= '0;
         reported_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         count_ff    <= count_in;
         reported_ff <= reported_in;
      end
   end

endmodule

`default_nettype wire

### design/distinct_window_marker_detector_top.sv
// ----------------------------------------------------------------------------
// distinct_window_marker_detector_top
// Finds the first position in each string at which the last window_length
// bytes are all distinct, using a last-seen-position table per byte value.
// ----------------------------------------------------------------------------
//  Port       Dir   Handshake        Payload
//  req_chan   in    valid/ready      data_byte[7:0], last_byte
//  rsp_chan   out   valid/ready      marker_position[15:0], marker_found
//  csr_*      in    write enable     window_length[5:0]
//
//  One byte per cycle sustained unless a held result stalls; a result
//  passes the table read, then the compare stage into the output register.
//  The throughput is set by the single read port of the position table; a
//  forwarding path covers a byte that repeats in the next transaction.
//  Reset is synchronous and clears all string state; the window is 14.
//  A held result stalls the compare stage, and the input stalls behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module distinct_window_marker_detector_top #(
   parameter int unsigned WINDOW_MAX   = 32,
   parameter int unsigned POSITION_MAX = 65535
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   dwmd_req_if.sink                        req_chan,
   dwmd_rsp_if.source                      rsp_chan,
   input  wire logic                       csr_wr_en,
   input  wire logic [dwmd_pkg::CFG_W-1:0] csr_wr_data
);

   localparam int unsigned POS_W = $clog2(POSITION_MAX + 2);
   localparam int unsigned RUN_W = $clog2(WINDOW_MAX + 1);

   logic [dwmd_pkg::CFG_W-1:0]     window_ff;
   logic                           s1_vld_ff,  s1_vld_in;
   logic [dwmd_pkg::DATA_W-1:0]    s1_byte_ff;
   logic                           s1_last_ff;
   logic                           fwd_vld_ff;
   logic [dwmd_pkg::DATA_W-1:0]    fwd_byte_ff;
   logic [POS_W-1:0]               fwd_pos_ff;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic [dwmd_pkg::OUT_POS_W-1:0] rsp_pos_ff;
   logic                           rsp_found_ff;

   logic                           accept;
   logic                           s1_fire;
   logic                           fwd_hit;
   logic [POS_W-1:0]               tbl_rd_data;
   logic                           tbl_seen;
   logic [POS_W-1:0]               last_pos;
   dwmd_pkg::tbl_ctrl_type         tbl_ctrl;
   logic [POS_W-1:0]               wr_pos;
   logic                           res_vld;
   logic                           res_found;
   logic [dwmd_pkg::OUT_POS_W-1:0] res_pos;

   // Handshake: compare stage advances when the output register frees up
   assign s1_fire        = s1_vld_ff && (!rsp_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || s1_fire;
   assign accept         = req_chan.valid && req_chan.ready;

   // Hold the window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= dwmd_pkg::WINDOW_RESET;
      end else if (csr_wr_en) begin
         window_ff <= csr_wr_data;
      end
   end

   // Advance the compare stage
   assign s1_vld_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
   end

   // Capture the table write that overlaps the read of the new transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_vld_ff <= 1'b0;
      end else if (accept) begin
         fwd_vld_ff <= tbl_ctrl.wr_en;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_byte_ff <= s1_byte_ff;
         fwd_pos_ff  <= wr_pos;
      end
   end

   assign fwd_hit  = fwd_vld_ff && (fwd_byte_ff == s1_byte_ff);
   assign last_pos = fwd_hit ? fwd_pos_ff : tbl_rd_data;

   dwmd_pos_table #(
      .POS_W (POS_W)
   ) u_pos_table (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (req_chan.data_byte),
      .rd_data  (tbl_rd_data),
      .chk_addr (s1_byte_ff),
      .chk_seen (tbl_seen),
      .ctrl     (tbl_ctrl),
      .wr_addr  (s1_byte_ff),
      .wr_data  (wr_pos)
   );

   dwmd_run_tracker #(
      .WINDOW_MAX   (WINDOW_MAX),
      .POSITION_MAX (POSITION_MAX),
      .POS_W        (POS_W),
      .RUN_W        (RUN_W)
   ) u_run_tracker (
      .clock         (clock),
      .reset         (reset),
      .fire          (s1_fire),
      .last_byte     (s1_last_ff),
      .seen          (tbl_seen),
      .last_pos      (last_pos),
      .window_length (window_ff),
      .tbl_ctrl      (tbl_ctrl),
      .wr_pos        (wr_pos),
      .res_vld       (res_vld),
      .res_found     (res_found),
      .res_pos       (res_pos)
   );

   // Load or drain the output register
   assign rsp_vld_in = s1_fire ? res_vld : (rsp_chan.ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && res_vld) begin
         rsp_pos_ff   <= res_pos;
         rsp_found_ff <= res_found;
      end
   end

   assign rsp_chan.valid           = rsp_vld_ff;
   assign rsp_chan.marker_position = rsp_pos_ff;
   assign rsp_chan.marker_found    = rsp_found_ff;

   // Checks
   `DWMD_ASSERT_NOW(a_notfound_zero, clock, reset, rsp_vld_ff && !rsp_found_ff, rsp_pos_ff == '0)
   `DWMD_ASSERT_NOW(a_found_nonzero, clock, reset, rsp_vld_ff && rsp_found_ff, rsp_pos_ff != '0)
   `DWMD_ASSERT_NEXT(a_accept_loads, clock, reset, accept, s1_vld_ff)
   `DWMD_ASSERT_NEXT(a_stall_holds, clock, reset, s1_vld_ff && !s1_fire, s1_vld_ff && $stable(s1_byte_ff))

endmodule

`default_nettype wire
